// ===== hw/rtl/request_credit_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Request credit tracker assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_CREDIT_TRACKER_TOP_MACROS_SVH
`define REQUEST_CREDIT_TRACKER_TOP_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define RCT_ASSERT_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Condition that must hold in the cycle after its trigger.
`define RCT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// Request credit tracker package
// Sizing constants, code types and the controller command bundle.
// ----------------------------------------------------------------------------
package rct_pkg;

  // Sizing.
  localparam int DRIVERS         = 8;
  localparam int SEND_GUARANTEED = 2;
  localparam int RECV_DEPTH      = 2;
  localparam int SPARES          = 8;
  localparam int RING            = SEND_GUARANTEED + SPARES;

  localparam int SEQ_W    = 32;
  localparam int LIMIT_W  = 8;
  localparam int SLOT_W   = (DRIVERS > 1) ? $clog2(DRIVERS) : 1;
  localparam int CNT_W    = $clog2(RING + 1);
  localparam int PTR_W    = (RING > 1) ? $clog2(RING) : 1;
  localparam int SUM_W    = CNT_W + 1;
  localparam int RCNT_W   = $clog2(RECV_DEPTH + 1);
  localparam int POOL_W   = (SPARES > 0) ? $clog2(SPARES + 1) : 1;
  localparam int RAM_DEPTH = DRIVERS * RING;
  localparam int ADDR_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_UP    = 3'd0,
    OP_INIT  = 3'd1,
    OP_ISSUE = 3'd2,
    OP_COMPL = 3'd3,
    OP_DOWN  = 3'd4
  } op_t;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_CFG  = 2'd0,
    KIND_SEND = 2'd1,
    KIND_RECV = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_BUSY     = 3'd1,
    STAT_IGNORED  = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_INACTIVE = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  // Per-slot head sequence numbers after reset.
  function automatic logic [SEQ_W-1:0] send_head_init(input int slot);
    send_head_init = SEQ_W'(slot) << 21;
  endfunction

  function automatic logic [SEQ_W-1:0] recv_head_init(input int slot);
    recv_head_init = SEQ_W'(slot * 2 + 1) << 20;
  endfunction

endpackage

// ===== hw/rtl/rct_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rct_ctrl.sv =====
// ----------------------------------------------------------------------------
// Request credit tracker controller
// Two-state sequencer: capture and read in idle, execute and write back.
// ----------------------------------------------------------------------------
module rct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output rct_pkg::cmd_t cmd
);

  rct_pkg::state_t state_r;
  rct_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rct_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = rct_pkg::S_EXEC;
        end
      end
      rct_pkg::S_EXEC: begin
        state_nxt = rct_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rct_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      rct_pkg::S_IDLE: begin
        cmd.load = start;
      end
      rct_pkg::S_EXEC: begin
        cmd.commit = 1'b1;
        busy       = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rct_dp.sv =====
// ----------------------------------------------------------------------------
// Request credit tracker datapath
// Per-slot queue state, spare pool, send kind ring and result registers.
// ----------------------------------------------------------------------------
`include "request_credit_tracker_top_macros.svh"

module rct_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rct_pkg::cmd_t                    cmd,
  input  logic [2:0]                       in_op,
  input  logic [2:0]                       in_driver,
  input  logic [1:0]                       in_kind,
  input  logic [31:0]                      in_seq_in,
  input  logic [7:0]                       in_send_depth,
  input  logic [7:0]                       in_recv_depth,
  input  logic                             in_info_ok,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [31:0]                      out_seq_out,
  output logic                             out_recv_room,
  output logic [3:0]                       out_spares_free
);

  // Per-slot state.
  logic                               pres_r [rct_pkg::DRIVERS];
  logic [rct_pkg::SEQ_W-1:0]          sh_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::SEQ_W-1:0]          rh_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::CNT_W-1:0]          sc_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::LIMIT_W-1:0]        sl_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::RCNT_W-1:0]         rc_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::RCNT_W-1:0]         rl_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::PTR_W-1:0]          rp_r   [rct_pkg::DRIVERS];
  logic [rct_pkg::POOL_W-1:0]         pool_r;

  // Captured beat and the addressed slot's state.
  logic [2:0]                         op_r;
  logic [2:0]                         slot_r;
  logic [1:0]                         kind_r;
  logic [rct_pkg::SEQ_W-1:0]          seq_r;
  logic [rct_pkg::LIMIT_W-1:0]        msend_r;
  logic [rct_pkg::LIMIT_W-1:0]        mrecv_r;
  logic                               ok_r;
  logic                               cur_pres_r;
  logic [rct_pkg::SEQ_W-1:0]          cur_sh_r;
  logic [rct_pkg::SEQ_W-1:0]          cur_rh_r;
  logic [rct_pkg::CNT_W-1:0]          cur_sc_r;
  logic [rct_pkg::LIMIT_W-1:0]        cur_sl_r;
  logic [rct_pkg::RCNT_W-1:0]         cur_rc_r;
  logic [rct_pkg::RCNT_W-1:0]         cur_rl_r;
  logic [rct_pkg::PTR_W-1:0]          cur_rp_r;

  // Result registers.
  logic                               out_valid_r;
  logic [2:0]                         out_status_r;
  logic [31:0]                        out_seq_out_r;
  logic                               out_recv_room_r;
  logic [3:0]                         out_spares_free_r;

  // Execute-cycle values.
  logic [rct_pkg::SLOT_W-1:0]         in_idx;
  logic [rct_pkg::SLOT_W-1:0]         s;
  logic                               slot_ok;
  logic                               active;
  logic                               kind_bad;
  logic                               kind_rd;
  logic [rct_pkg::ADDR_W-1:0]         raddr;
  logic [rct_pkg::ADDR_W-1:0]         waddr;
  logic                               ring_we;
  logic [rct_pkg::CNT_W-1:0]          ret;
  logic [rct_pkg::POOL_W:0]           pool_sum;
  logic [rct_pkg::POOL_W-1:0]         pool_fl;
  logic [rct_pkg::SUM_W-1:0]          rp_sum;
  logic [rct_pkg::PTR_W-1:0]          rp_fl;
  logic [rct_pkg::PTR_W-1:0]          rp_inc;
  logic [rct_pkg::SEQ_W-1:0]          sh_fl;
  logic [rct_pkg::SEQ_W-1:0]          rh_fl;
  logic                               do_flush;
  logic                               pres_nxt;
  logic [rct_pkg::SEQ_W-1:0]          sh_nxt;
  logic [rct_pkg::SEQ_W-1:0]          rh_nxt;
  logic [rct_pkg::CNT_W-1:0]          sc_nxt;
  logic [rct_pkg::LIMIT_W-1:0]        sl_nxt;
  logic [rct_pkg::RCNT_W-1:0]         rc_nxt;
  logic [rct_pkg::RCNT_W-1:0]         rl_nxt;
  logic [rct_pkg::PTR_W-1:0]          rp_nxt;
  logic [rct_pkg::POOL_W-1:0]         pool_nxt;
  rct_pkg::status_t                   status;
  logic [rct_pkg::SEQ_W-1:0]          seq_o;

  assign in_idx  = rct_pkg::SLOT_W'(in_driver);
  assign s       = rct_pkg::SLOT_W'(slot_r);
  assign slot_ok = 32'(slot_r) < rct_pkg::DRIVERS;

  // Ring read of the head kind, issued with the accepted beat.
  assign raddr = rct_pkg::ADDR_W'(32'(in_idx) * rct_pkg::RING + 32'(rp_r[in_idx]));

  rct_ram #(
    .WIDTH (1),
    .DEPTH (rct_pkg::RAM_DEPTH)
  ) u_kind_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (waddr),
    .wdata (kind_r[0]),
    .re    (cmd.load),
    .raddr (raddr),
    .rdata (kind_rd)
  );

  // Capture the beat and the addressed slot's state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      slot_r     <= in_driver;
      kind_r     <= in_kind;
      seq_r      <= in_seq_in;
      msend_r    <= in_send_depth;
      mrecv_r    <= in_recv_depth;
      ok_r       <= in_info_ok;
      cur_pres_r <= pres_r[in_idx];
      cur_sh_r   <= sh_r[in_idx];
      cur_rh_r   <= rh_r[in_idx];
      cur_sc_r   <= sc_r[in_idx];
      cur_sl_r   <= sl_r[in_idx];
      cur_rc_r   <= rc_r[in_idx];
      cur_rl_r   <= rl_r[in_idx];
      cur_rp_r   <= rp_r[in_idx];
    end
  end

  // Flush arithmetic: heads advance by the counts, spares above the
  // guaranteed depth go back to the pool, the read pointer skips the entries.
  always_comb begin
    ret = (32'(cur_sc_r) > rct_pkg::SEND_GUARANTEED) ?
          cur_sc_r - rct_pkg::CNT_W'(rct_pkg::SEND_GUARANTEED) : '0;
    pool_sum = {1'b0, pool_r} + (rct_pkg::POOL_W + 1)'(ret);
    pool_fl  = (pool_sum > (rct_pkg::POOL_W + 1)'(rct_pkg::SPARES)) ?
               rct_pkg::POOL_W'(rct_pkg::SPARES) : rct_pkg::POOL_W'(pool_sum);
    rp_sum   = rct_pkg::SUM_W'(cur_rp_r) + rct_pkg::SUM_W'(cur_sc_r);
    rp_fl    = (rp_sum >= rct_pkg::SUM_W'(rct_pkg::RING)) ?
               rct_pkg::PTR_W'(rp_sum - rct_pkg::SUM_W'(rct_pkg::RING)) :
               rct_pkg::PTR_W'(rp_sum);
    rp_inc   = (32'(cur_rp_r) == rct_pkg::RING - 1) ? '0 : cur_rp_r + 1'b1;
    sh_fl    = cur_sh_r + rct_pkg::SEQ_W'(cur_sc_r);
    rh_fl    = cur_rh_r + rct_pkg::SEQ_W'(cur_rc_r);
  end

  assign active   = cur_pres_r && (cur_sl_r != '0);
  assign kind_bad = (kind_r != rct_pkg::KIND_CFG) && (kind_r != rct_pkg::KIND_SEND) &&
                    (kind_r != rct_pkg::KIND_RECV);
  assign waddr    = rct_pkg::ADDR_W'(32'(s) * rct_pkg::RING + 32'(rp_fl));

  // Operation decode and next slot state.
  always_comb begin
    pres_nxt = cur_pres_r;
    sh_nxt   = cur_sh_r;
    rh_nxt   = cur_rh_r;
    sc_nxt   = cur_sc_r;
    sl_nxt   = cur_sl_r;
    rc_nxt   = cur_rc_r;
    rl_nxt   = cur_rl_r;
    rp_nxt   = cur_rp_r;
    pool_nxt = pool_r;
    status   = rct_pkg::STAT_IGNORED;
    seq_o    = '0;
    do_flush = 1'b0;
    ring_we  = 1'b0;
    if (slot_ok) begin
      unique case (op_r)
        rct_pkg::OP_UP: begin
          status = rct_pkg::STAT_DONE;
          if (cur_pres_r) begin
            do_flush = 1'b1;
            seq_o    = sh_fl;
          end else begin
            pres_nxt = 1'b1;
            sh_nxt   = cur_sh_r + 1'b1;
            rh_nxt   = cur_rh_r + 1'b1;
            sc_nxt   = '0;
            sl_nxt   = '0;
            rc_nxt   = '0;
            rl_nxt   = '0;
            seq_o    = cur_sh_r + 1'b1;
          end
        end
        rct_pkg::OP_INIT: begin
          if (!cur_pres_r) begin
            status = rct_pkg::STAT_INACTIVE;
          end else if ((cur_sl_r != '0) || (seq_r != cur_sh_r)) begin
            status = rct_pkg::STAT_IGNORED;
          end else if (!ok_r || (msend_r == '0) || (mrecv_r == '0)) begin
            do_flush = 1'b1;
            pres_nxt = 1'b0;
            status   = rct_pkg::STAT_REJECTED;
          end else begin
            sl_nxt = msend_r;
            sh_nxt = cur_sh_r + 1'b1;
            rl_nxt = (32'(mrecv_r) > rct_pkg::RECV_DEPTH) ?
                     rct_pkg::RCNT_W'(rct_pkg::RECV_DEPTH) : rct_pkg::RCNT_W'(mrecv_r);
            rh_nxt = cur_rh_r + 1'b1;
            status = rct_pkg::STAT_DONE;
          end
        end
        rct_pkg::OP_DOWN: begin
          if (!cur_pres_r) begin
            status = rct_pkg::STAT_INACTIVE;
          end else begin
            do_flush = 1'b1;
            pres_nxt = 1'b0;
            status   = rct_pkg::STAT_DONE;
          end
        end
        rct_pkg::OP_ISSUE: begin
          if (!active) begin
            status = rct_pkg::STAT_INACTIVE;
          end else if (kind_bad) begin
            status = rct_pkg::STAT_IGNORED;
          end else if (kind_r == rct_pkg::KIND_RECV) begin
            if (cur_rc_r >= cur_rl_r) begin
              status = rct_pkg::STAT_BUSY;
            end else begin
              seq_o  = cur_rh_r + rct_pkg::SEQ_W'(cur_rc_r);
              rc_nxt = cur_rc_r + 1'b1;
              status = rct_pkg::STAT_DONE;
            end
          end else if ((32'(cur_sc_r) >= 32'(cur_sl_r)) ||
                       (32'(cur_sc_r) >= rct_pkg::RING) ||
                       ((32'(cur_sc_r) >= rct_pkg::SEND_GUARANTEED) && (pool_r == '0))) begin
            status = rct_pkg::STAT_BUSY;
          end else begin
            if (32'(cur_sc_r) >= rct_pkg::SEND_GUARANTEED) begin
              pool_nxt = pool_r - 1'b1;
            end
            seq_o   = sh_fl;
            ring_we = 1'b1;
            sc_nxt  = cur_sc_r + 1'b1;
            status  = rct_pkg::STAT_DONE;
          end
        end
        rct_pkg::OP_COMPL: begin
          if (!active) begin
            status = rct_pkg::STAT_INACTIVE;
          end else if (kind_bad) begin
            status = rct_pkg::STAT_IGNORED;
          end else if (kind_r == rct_pkg::KIND_RECV) begin
            if ((cur_rc_r == '0) || (cur_rh_r != seq_r)) begin
              status = rct_pkg::STAT_IGNORED;
            end else begin
              rh_nxt = cur_rh_r + 1'b1;
              rc_nxt = cur_rc_r - 1'b1;
              status = rct_pkg::STAT_DONE;
            end
          end else if ((cur_sc_r == '0) || (cur_sh_r != seq_r) || (kind_rd != kind_r[0])) begin
            status = rct_pkg::STAT_IGNORED;
          end else begin
            if ((32'(cur_sc_r) > rct_pkg::SEND_GUARANTEED) &&
                (32'(pool_r) < rct_pkg::SPARES)) begin
              pool_nxt = pool_r + 1'b1;
            end
            rp_nxt = rp_inc;
            sh_nxt = cur_sh_r + 1'b1;
            sc_nxt = cur_sc_r - 1'b1;
            status = rct_pkg::STAT_DONE;
          end
        end
        default: begin
          status = rct_pkg::STAT_IGNORED;
        end
      endcase
      // Flush empties both queues of the slot in one step.
      if (do_flush) begin
        sh_nxt   = sh_fl;
        rh_nxt   = rh_fl;
        rp_nxt   = rp_fl;
        pool_nxt = pool_fl;
        sc_nxt   = '0;
        sl_nxt   = '0;
        rc_nxt   = '0;
        rl_nxt   = '0;
      end
    end
  end

  // Slot state write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rct_pkg::DRIVERS; i++) begin
        pres_r[i] <= 1'b0;
        sh_r[i]   <= rct_pkg::send_head_init(i);
        rh_r[i]   <= rct_pkg::recv_head_init(i);
        sc_r[i]   <= '0;
        sl_r[i]   <= '0;
        rc_r[i]   <= '0;
        rl_r[i]   <= '0;
        rp_r[i]   <= '0;
      end
      pool_r <= rct_pkg::POOL_W'(rct_pkg::SPARES);
    end else if (cmd.commit && slot_ok) begin
      pres_r[s] <= pres_nxt;
      sh_r[s]   <= sh_nxt;
      rh_r[s]   <= rh_nxt;
      sc_r[s]   <= sc_nxt;
      sl_r[s]   <= sl_nxt;
      rc_r[s]   <= rc_nxt;
      rl_r[s]   <= rl_nxt;
      rp_r[s]   <= rp_nxt;
      pool_r    <= pool_nxt;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r      <= status;
      out_seq_out_r     <= seq_o;
      out_recv_room_r   <= slot_ok && (rc_nxt < rl_nxt);
      out_spares_free_r <= 4'(pool_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_seq_out     = out_seq_out_r;
  assign out_recv_room   = out_recv_room_r;
  assign out_spares_free = out_spares_free_r;

  // Checks.
  `RCT_ASSERT_IMPLY(a_pool_bound, 1'b1, 32'(pool_r) <= rct_pkg::SPARES)
  `RCT_ASSERT_IMPLY(a_recv_within_limit, cmd.commit && slot_ok, rc_nxt <= rl_nxt)
  `RCT_ASSERT_NEXT(a_strobe_after_commit, cmd.commit, out_valid_r)
  `RCT_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r)

endmodule

// ===== hw/rtl/request_credit_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Request credit tracker
// Per-driver send and receive request queues with a shared spare pool.
//
//   Channel   Handshake               Ports
//   input     start & !busy           in_op .. in_info_ok
//   result    out_valid, one cycle    out_status .. out_spares_free
//
// The accepting edge reads the slot's state and the send kind ring, the
// execute state writes the slot back, and the result beat shows in the
// following cycle, while busy is already low again.
// The send kind ring is a registered-read RAM.
// Reset is synchronous; the ring needs no clearing pass.
// The receiver cannot stall: each result beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
module request_credit_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_driver,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_seq_in,
  input  logic [7:0]  in_send_depth,
  input  logic [7:0]  in_recv_depth,
  input  logic        in_info_ok,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_seq_out,
  output logic        out_recv_room,
  output logic [3:0]  out_spares_free
);

  rct_pkg::cmd_t cmd;

  // Sequencer.
  rct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Queue state and result datapath.
  rct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_driver       (in_driver),
    .in_kind         (in_kind),
    .in_seq_in       (in_seq_in),
    .in_send_depth   (in_send_depth),
    .in_recv_depth   (in_recv_depth),
    .in_info_ok      (in_info_ok),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_seq_out     (out_seq_out),
    .out_recv_room   (out_recv_room),
    .out_spares_free (out_spares_free)
  );

endmodule

// ===== tb/tb_request_credit_tracker_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request credit tracker testbench
// A driver offers request beats from a queue and a clocked predictor works
// out the result of each accepted beat. A monitor compares every result beat
// with the oldest prediction, field by field. Stimulus is a directed opening
// followed by random bring-up, traffic and tear-down sessions mixed with noise.
// ----------------------------------------------------------------------------
module tb_request_credit_tracker_top;

  // Codes outside the defined sets, and run sizing.
  localparam logic [2:0] OP_RSVD5  = 3'd5;
  localparam logic [2:0] OP_RSVD7  = 3'd7;
  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam int SEND_HEAD_SHIFT = 21;
  localparam int RECV_HEAD_SHIFT = 20;
  localparam int USEFUL_TARGET   = 2000;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;

  // How a request picks its sequence id and kind when it is offered.
  typedef enum {SEQ_LITERAL, SEQ_SEND_HEAD, SEQ_RECV_HEAD} seq_pick_t;
  typedef enum {KIND_LITERAL, KIND_OLDEST_SEND, KIND_WRONG_SEND} kind_pick_t;

  typedef struct {
    logic [2:0]  op;
    logic [2:0]  drv;
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [7:0]  send_depth;
    logic [7:0]  recv_depth;
    logic        ok;
    seq_pick_t   seq_pick;
    logic [31:0] seq_adj;
    kind_pick_t  kind_pick;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] seq;
    logic        room;
    logic [3:0]  spares;
  } credit_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [2:0]  in_driver = '0;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_seq_in = '0;
  logic [7:0]  in_send_depth = '0;
  logic [7:0]  in_recv_depth = '0;
  logic        in_info_ok = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_seq_out;
  logic        out_recv_room;
  logic [3:0]  out_spares_free;

  request_credit_tracker_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_driver      (in_driver),
    .in_kind        (in_kind),
    .in_seq_in      (in_seq_in),
    .in_send_depth  (in_send_depth),
    .in_recv_depth  (in_recv_depth),
    .in_info_ok     (in_info_ok),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_seq_out    (out_seq_out),
    .out_recv_room  (out_recv_room),
    .out_spares_free(out_spares_free)
  );

  // Predicted tracker state, one entry per driver slot.
  bit          slot_up  [rct_pkg::DRIVERS];
  logic [31:0] send_hd  [rct_pkg::DRIVERS];
  logic [31:0] recv_hd  [rct_pkg::DRIVERS];
  int          send_cnt [rct_pkg::DRIVERS];
  int          send_lim [rct_pkg::DRIVERS];
  int          recv_cnt [rct_pkg::DRIVERS];
  int          recv_lim [rct_pkg::DRIVERS];
  int          send_rd  [rct_pkg::DRIVERS];
  logic [1:0]  kind_ring[rct_pkg::DRIVERS][rct_pkg::RING];
  int          spare_pool;

  request_t       request_queue[$];
  credit_result_t pending_results[$];
  request_t       current;
  credit_result_t expected;
  credit_result_t observed;
  bit             offering;
  int             hold_off;
  int             requests_taken;
  int             beats_checked;
  int             mismatch_count;
  int             cycle_count;
  int             outcome_tally[5];
  int             pool_low = rct_pkg::SPARES;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Returns one spare entry to the shared pool, saturating at its size.
  function automatic void return_spare();
    if (spare_pool < rct_pkg::SPARES) spare_pool++;
  endfunction

  // Retires every outstanding entry of a slot and clears its limits.
  function automatic void flush_queues(int s);
    for (int i = send_cnt[s]; i > rct_pkg::SEND_GUARANTEED; i--) return_spare();
    send_hd[s]  = send_hd[s] + 32'(send_cnt[s]);
    send_rd[s]  = (send_rd[s] + send_cnt[s]) % rct_pkg::RING;
    send_cnt[s] = 0;
    send_lim[s] = 0;
    recv_hd[s]  = recv_hd[s] + 32'(recv_cnt[s]);
    recv_cnt[s] = 0;
    recv_lim[s] = 0;
  endfunction

  // Applies one accepted request to the predicted state and returns its result.
  function automatic credit_result_t predict_credit(request_t rq);
    credit_result_t r;
    int s;
    int c;
    int rp;
    bit live;
    s = rq.drv;
    r.status = rct_pkg::STAT_IGNORED;
    r.seq = '0;
    live = slot_up[s] && send_lim[s] > 0;
    case (rq.op)
      rct_pkg::OP_UP: begin
        if (slot_up[s]) begin
          flush_queues(s);
        end else begin
          slot_up[s]  = 1'b1;
          send_hd[s]  = send_hd[s] + 1;
          recv_hd[s]  = recv_hd[s] + 1;
          send_cnt[s] = 0;
          send_lim[s] = 0;
          recv_cnt[s] = 0;
          recv_lim[s] = 0;
        end
        r.status = rct_pkg::STAT_DONE;
        r.seq = send_hd[s];
      end
      rct_pkg::OP_INIT: begin
        if (!slot_up[s]) begin
          r.status = rct_pkg::STAT_INACTIVE;
        end else if (send_lim[s] > 0 || rq.seq != send_hd[s]) begin
          r.status = rct_pkg::STAT_IGNORED;
        end else if (!rq.ok || rq.send_depth == 0 || rq.recv_depth == 0) begin
          flush_queues(s);
          slot_up[s] = 1'b0;
          r.status = rct_pkg::STAT_REJECTED;
        end else begin
          send_lim[s] = rq.send_depth;
          send_hd[s]  = send_hd[s] + 1;
          recv_lim[s] = (rq.recv_depth > rct_pkg::RECV_DEPTH) ? rct_pkg::RECV_DEPTH
                                                               : rq.recv_depth;
          recv_hd[s]  = recv_hd[s] + 1;
          r.status = rct_pkg::STAT_DONE;
        end
      end
      rct_pkg::OP_DOWN: begin
        if (!slot_up[s]) begin
          r.status = rct_pkg::STAT_INACTIVE;
        end else begin
          flush_queues(s);
          slot_up[s] = 1'b0;
          r.status = rct_pkg::STAT_DONE;
        end
      end
      rct_pkg::OP_ISSUE, rct_pkg::OP_COMPL: begin
        c = send_cnt[s];
        rp = send_rd[s] % rct_pkg::RING;
        if (!live) begin
          r.status = rct_pkg::STAT_INACTIVE;
        end else if (rq.kind == KIND_RSVD) begin
          r.status = rct_pkg::STAT_IGNORED;
        end else if (rq.op == rct_pkg::OP_ISSUE && rq.kind == rct_pkg::KIND_RECV) begin
          if (recv_cnt[s] >= recv_lim[s]) begin
            r.status = rct_pkg::STAT_BUSY;
          end else begin
            r.seq = recv_hd[s] + 32'(recv_cnt[s]);
            recv_cnt[s]++;
            r.status = rct_pkg::STAT_DONE;
          end
        end else if (rq.op == rct_pkg::OP_ISSUE) begin
          if (c >= send_lim[s] || c >= rct_pkg::RING ||
              (c >= rct_pkg::SEND_GUARANTEED && spare_pool == 0)) begin
            r.status = rct_pkg::STAT_BUSY;
          end else begin
            if (c >= rct_pkg::SEND_GUARANTEED) spare_pool--;
            r.seq = send_hd[s] + 32'(c);
            kind_ring[s][(send_rd[s] + c) % rct_pkg::RING] = rq.kind;
            send_cnt[s] = c + 1;
            r.status = rct_pkg::STAT_DONE;
          end
        end else if (rq.kind == rct_pkg::KIND_RECV) begin
          if (recv_cnt[s] < 1 || recv_hd[s] != rq.seq) begin
            r.status = rct_pkg::STAT_IGNORED;
          end else begin
            recv_hd[s] = recv_hd[s] + 1;
            recv_cnt[s]--;
            r.status = rct_pkg::STAT_DONE;
          end
        end else begin
          if (c < 1 || send_hd[s] != rq.seq || kind_ring[s][rp] != rq.kind) begin
            r.status = rct_pkg::STAT_IGNORED;
          end else begin
            if (c > rct_pkg::SEND_GUARANTEED) return_spare();
            send_rd[s]  = (rp + 1) % rct_pkg::RING;
            send_hd[s]  = send_hd[s] + 1;
            send_cnt[s] = c - 1;
            r.status = rct_pkg::STAT_DONE;
          end
        end
      end
      default: r.status = rct_pkg::STAT_IGNORED;
    endcase
    r.room = recv_cnt[s] < recv_lim[s];
    r.spares = 4'(spare_pool);
    return r;
  endfunction

  // A request with random filler in the fields its operation does not use.
  function automatic request_t fresh_request(logic [2:0] op, logic [2:0] drv);
    request_t rq;
    rq.op = op;
    rq.drv = drv;
    rq.kind = 2'($urandom_range(rct_pkg::KIND_CFG, rct_pkg::KIND_RECV));
    rq.seq = $urandom;
    rq.send_depth = 8'($urandom);
    rq.recv_depth = 8'($urandom);
    rq.ok = 1'($urandom);
    rq.seq_pick = SEQ_LITERAL;
    rq.seq_adj = '0;
    rq.kind_pick = KIND_LITERAL;
    return rq;
  endfunction

  // Counts a mismatch and prints it.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s at beat %0d: got 0x%0h, want 0x%0h",
             $time, field, beats_checked, got, want);
  endtask

  // Driver: offers one request beat at a time, predicts it when accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < rct_pkg::DRIVERS; s++) begin
        slot_up[s]  = 1'b0;
        send_hd[s]  = 32'(s) << SEND_HEAD_SHIFT;
        recv_hd[s]  = 32'(2 * s + 1) << RECV_HEAD_SHIFT;
        send_cnt[s] = 0;
        send_lim[s] = 0;
        recv_cnt[s] = 0;
        recv_lim[s] = 0;
        send_rd[s]  = 0;
        for (int e = 0; e < rct_pkg::RING; e++) kind_ring[s][e] = rct_pkg::KIND_CFG;
      end
      spare_pool = rct_pkg::SPARES;
      offering = 1'b0;
      hold_off = 0;
      start <= 1'b0;
    end else begin
      if (offering && !busy) begin
        pending_results.push_back(predict_credit(current));
        requests_taken++;
        offering = 1'b0;
        hold_off = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (!offering) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (request_queue.size() > 0) begin
          current = request_queue.pop_front();
          // Ids and kinds that must match the live state are settled now.
          case (current.seq_pick)
            SEQ_SEND_HEAD: current.seq = send_hd[current.drv] + current.seq_adj;
            SEQ_RECV_HEAD: current.seq = recv_hd[current.drv] + current.seq_adj;
            default: ;
          endcase
          if (current.kind_pick != KIND_LITERAL && send_cnt[current.drv] > 0) begin
            current.kind = kind_ring[current.drv][send_rd[current.drv] % rct_pkg::RING];
            if (current.kind_pick == KIND_WRONG_SEND)
              current.kind = (current.kind == rct_pkg::KIND_CFG) ? rct_pkg::KIND_SEND
                                                                 : rct_pkg::KIND_CFG;
          end
          in_op         <= current.op;
          in_driver     <= current.drv;
          in_kind       <= current.kind;
          in_seq_in     <= current.seq;
          in_send_depth <= current.send_depth;
          in_recv_depth <= current.recv_depth;
          in_info_ok    <= current.ok;
          offering = 1'b1;
        end
      end
      start <= offering;
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_status), '0);
      end else begin
        expected = pending_results.pop_front();
        observed.status = out_status;
        observed.seq = out_seq_out;
        observed.room = out_recv_room;
        observed.spares = out_spares_free;
        if (observed.status !== expected.status)
          report_mismatch("status", 32'(observed.status), 32'(expected.status));
        if (observed.seq !== expected.seq)
          report_mismatch("seq_out", observed.seq, expected.seq);
        if (observed.room !== expected.room)
          report_mismatch("recv_room", 32'(observed.room), 32'(expected.room));
        if (observed.spares !== expected.spares)
          report_mismatch("spares_free", 32'(observed.spares), 32'(expected.spares));
        outcome_tally[expected.status]++;
        if (int'(expected.spares) < pool_low) pool_low = expected.spares;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    request_t rq;
    int useful;
    int slot;
    int traffic_len;
    int target;
    bit filling;
    int closing;

    // Requests to slots that were never brought up.
    rq = fresh_request(rct_pkg::OP_COMPL, 3'd0);
    rq.seq = '0;
    request_queue.push_back(rq);
    request_queue.push_back(fresh_request(rct_pkg::OP_INIT, 3'd1));
    request_queue.push_back(fresh_request(rct_pkg::OP_DOWN, 3'd2));
    rq = fresh_request(rct_pkg::OP_ISSUE, 3'd3);
    rq.kind = rct_pkg::KIND_SEND;
    request_queue.push_back(rq);

    // Bring-up of slot 0: issue before init, stale init id, widest limits.
    request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'd0));
    rq = fresh_request(rct_pkg::OP_ISSUE, 3'd0);
    rq.kind = rct_pkg::KIND_CFG;
    request_queue.push_back(rq);
    rq = fresh_request(rct_pkg::OP_INIT, 3'd0);
    rq.seq = '1;
    rq.ok = 1'b1;
    rq.send_depth = 8'd4;
    rq.recv_depth = 8'd2;
    request_queue.push_back(rq);
    rq.seq_pick = SEQ_SEND_HEAD;
    rq.send_depth = '1;
    rq.recv_depth = '1;
    request_queue.push_back(rq);
    request_queue.push_back(rq);

    // Reserved kind and unused operations on an active slot.
    rq = fresh_request(rct_pkg::OP_ISSUE, 3'd0);
    rq.kind = KIND_RSVD;
    request_queue.push_back(rq);
    request_queue.push_back(fresh_request(OP_RSVD5, 3'd0));
    request_queue.push_back(fresh_request(OP_RSVD7, 3'd0));

    // Receive queue: fill past its clamped depth, then a missed and a good completion.
    rq = fresh_request(rct_pkg::OP_ISSUE, 3'd0);
    rq.kind = rct_pkg::KIND_RECV;
    repeat (3) request_queue.push_back(rq);
    rq = fresh_request(rct_pkg::OP_COMPL, 3'd0);
    rq.kind = rct_pkg::KIND_RECV;
    rq.seq_pick = SEQ_RECV_HEAD;
    rq.seq_adj = 32'd1;
    request_queue.push_back(rq);
    rq.seq_adj = '0;
    request_queue.push_back(rq);

    // Send queue: configure and send, then a completion of the wrong kind and one of the right kind.
    rq = fresh_request(rct_pkg::OP_ISSUE, 3'd0);
    rq.kind = rct_pkg::KIND_CFG;
    request_queue.push_back(rq);
    rq.kind = rct_pkg::KIND_SEND;
    request_queue.push_back(rq);
    rq = fresh_request(rct_pkg::OP_COMPL, 3'd0);
    rq.seq_pick = SEQ_SEND_HEAD;
    rq.kind_pick = KIND_WRONG_SEND;
    request_queue.push_back(rq);
    rq.kind_pick = KIND_OLDEST_SEND;
    request_queue.push_back(rq);

    // Init replies that fail their checks or offer no send depth.
    request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'd1));
    rq = fresh_request(rct_pkg::OP_INIT, 3'd1);
    rq.seq_pick = SEQ_SEND_HEAD;
    rq.ok = 1'b0;
    rq.send_depth = 8'd1;
    rq.recv_depth = 8'd1;
    request_queue.push_back(rq);
    request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'd2));
    rq = fresh_request(rct_pkg::OP_INIT, 3'd2);
    rq.seq_pick = SEQ_SEND_HEAD;
    rq.ok = 1'b1;
    rq.send_depth = '0;
    rq.recv_depth = 8'd1;
    request_queue.push_back(rq);

    // Driver up on a busy slot flushes it; then take it down.
    request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'd0));
    request_queue.push_back(fresh_request(rct_pkg::OP_DOWN, 3'd0));

    // Random sessions: bring-up, fill and drain traffic, optional tear-down.
    useful = 0;
    while (useful < USEFUL_TARGET) begin
      slot = $urandom_range(0, rct_pkg::DRIVERS - 1);
      request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'(slot)));
      rq = fresh_request(rct_pkg::OP_INIT, 3'(slot));
      rq.seq_pick = SEQ_SEND_HEAD;
      rq.ok = 1'b1;
      rq.send_depth = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 12));
      rq.recv_depth = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 3));
      // Now and then a broken init reply.
      case ($urandom_range(0, 15))
        0: rq.ok = 1'b0;
        1: rq.send_depth = '0;
        2: rq.recv_depth = '0;
        3: rq.seq_adj = $urandom_range(1, 3);
        default: ;
      endcase
      request_queue.push_back(rq);
      useful += 2;

      traffic_len = $urandom_range(8, 40);
      for (int n = 0; n < traffic_len; n++) begin
        filling = n < traffic_len / 2;
        target = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rct_pkg::DRIVERS - 1)
                                              : slot;
        if ($urandom_range(0, 11) == 0) begin
          // Noise: every field at random.
          rq = fresh_request(3'($urandom), 3'($urandom));
          rq.kind = 2'($urandom);
        end else if ($urandom_range(0, 99) < (filling ? 80 : 25)) begin
          rq = fresh_request(rct_pkg::OP_ISSUE, 3'(target));
          if ($urandom_range(0, 29) == 0) rq.kind = KIND_RSVD;
          useful++;
        end else begin
          rq = fresh_request(rct_pkg::OP_COMPL, 3'(target));
          if ($urandom_range(0, 2) == 0) begin
            rq.kind = rct_pkg::KIND_RECV;
            rq.seq_pick = SEQ_RECV_HEAD;
          end else begin
            rq.seq_pick = SEQ_SEND_HEAD;
            rq.kind_pick = ($urandom_range(0, 9) == 0) ? KIND_WRONG_SEND : KIND_OLDEST_SEND;
          end
          if ($urandom_range(0, 9) == 0)
            rq.seq_adj = ($urandom_range(0, 1) == 0) ? 32'd1 : '1;
          useful++;
        end
        request_queue.push_back(rq);
      end

      closing = $urandom_range(0, 2);
      if (closing == 0) begin
        request_queue.push_back(fresh_request(rct_pkg::OP_DOWN, 3'(slot)));
        useful++;
      end else if (closing == 1) begin
        request_queue.push_back(fresh_request(rct_pkg::OP_UP, 3'(slot)));
        useful++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || offering) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d result beats in %0d cycles.",
             requests_taken, beats_checked, cycle_count);
    $display("Outcomes: %0d done, %0d busy, %0d ignored, %0d rejected, %0d not active; %s %0d.",
             outcome_tally[rct_pkg::STAT_DONE], outcome_tally[rct_pkg::STAT_BUSY],
             outcome_tally[rct_pkg::STAT_IGNORED], outcome_tally[rct_pkg::STAT_REJECTED],
             outcome_tally[rct_pkg::STAT_INACTIVE], "spare pool low", pool_low);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
